### hdl/sih_pkg.sv
// shared constants, types and codes for the stack intern hash table
package sih_pkg;

   localparam int CAPACITY  = 1024;
   localparam int MAX_DEPTH = 64;
   localparam int SLOT_W    = $clog2(CAPACITY);
   localparam int IDX_W     = $clog2(MAX_DEPTH);
   localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
   localparam int TOTAL_W   = 11;
   localparam int LIMIT_W   = 7;
   localparam int STATUS_W  = 3;

   localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
   localparam logic [8:0]  FNV_LOW   = 9'h1B3;
   localparam int          FNV_SHIFT = 40;
   localparam logic [LIMIT_W-1:0] PROBE_MAX   = LIMIT_W'(64);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);
   localparam logic [TOTAL_W-1:0] TOTAL_MAX   = TOTAL_W'(2047);

   localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

   typedef enum logic [1:0] {
      KIND_FOUND,
      KIND_INSERTED,
      KIND_FULL,
      KIND_READ
   } out_kind_type;

   typedef struct packed {
      logic         clr_step;
      logic         load_req;
      logic         hash_step;
      logic         start_probe;
      logic         slot_read;
      logic         next_probe;
      logic         ins_meta;
      logic         cmp_start;
      logic         frame_read;
      logic         cmp_next;
      logic         copy_write;
      logic         out_load;
      out_kind_type kind;
   } sih_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic req_is_read;
      logic pend_full;
      logic last_flag;
      logic byte_last;
      logic probes_done;
      logic slot_empty;
      logic slot_match;
      logic frames_done;
      logic frame_eq;
   } sih_status_type;

endpackage

### hdl/sih_datapath.sv
// datapath: hashing, slot tables, frame store and result registers
module sih_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  sih_pkg::sih_cmd_type          cmd,
   output sih_pkg::sih_status_type       sts,
   input  logic                          req_type,
   input  logic [63:0]                   req_frame_addr,
   input  logic                          req_last_frame,
   input  logic [9:0]                    req_slot_id,
   input  logic [5:0]                    req_frame_index,
   input  logic                          csr_wr_en,
   input  logic [6:0]                    csr_wr_data,
   output logic [9:0]                    rsp_result_id,
   output logic [2:0]                    rsp_status,
   output logic [63:0]                   rsp_frame_out,
   output logic [6:0]                    rsp_stack_depth,
   output logic [10:0]                   rsp_stored_count
);

   localparam int FR_AW = sih_pkg::SLOT_W + sih_pkg::IDX_W;

   logic [63:0] slot_hash_mem [sih_pkg::CAPACITY];
   logic [sih_pkg::CNT_W-1:0] slot_depth_mem [sih_pkg::CAPACITY];
   logic [63:0] slot_frames_mem [sih_pkg::CAPACITY * sih_pkg::MAX_DEPTH];
   logic [63:0] pend_mem [sih_pkg::MAX_DEPTH];

   logic [63:0] hash_ff, hash_in;
   logic [sih_pkg::CNT_W-1:0] pend_cnt_ff, pend_cnt_in;
   logic [sih_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [sih_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [sih_pkg::SLOT_W-1:0] clr_ff, clr_in;

   logic [63:0] frame_ff;
   logic [2:0] byte_ff;
   logic type_ff, last_ff;
   logic [sih_pkg::SLOT_W-1:0] slot_ff;
   logic [sih_pkg::IDX_W-1:0] findex_ff;
   logic [63:0] fh_ff;
   logic [sih_pkg::CNT_W-1:0] depth_ff;
   logic [sih_pkg::SLOT_W-1:0] idx_ff;
   logic [sih_pkg::LIMIT_W-1:0] probe_ff;
   logic [sih_pkg::CNT_W-1:0] i_ff;

   logic [63:0] rd_hash_ff, rd_frame_ff, rd_pend_ff;
   logic [sih_pkg::CNT_W-1:0] rd_depth_ff;

   logic [63:0] mix, fold, adj_hash;
   logic [sih_pkg::LIMIT_W-1:0] lim_eff;
   logic [sih_pkg::SLOT_W-1:0] meta_addr;
   logic [FR_AW-1:0] fr_addr;

   assign mix      = hash_ff ^ {56'd0, frame_ff[7:0]};
   assign fold     = (mix << sih_pkg::FNV_SHIFT) + (mix * {55'd0, sih_pkg::FNV_LOW});
   assign adj_hash = (hash_ff < 64'd2) ? hash_ff + 64'd2 : hash_ff;
   assign lim_eff  = (limit_ff > sih_pkg::PROBE_MAX) ? sih_pkg::PROBE_MAX : limit_ff;
   assign meta_addr = type_ff ? slot_ff : idx_ff;
   assign fr_addr  = cmd.frame_read ? {idx_ff, i_ff[sih_pkg::IDX_W-1:0]}
                                    : {slot_ff, findex_ff};

   assign sts.clr_last    = clr_ff == sih_pkg::SLOT_W'(sih_pkg::CAPACITY - 1);
   assign sts.req_is_read = type_ff;
   assign sts.pend_full   = pend_cnt_ff == sih_pkg::CNT_W'(sih_pkg::MAX_DEPTH);
   assign sts.last_flag   = last_ff;
   assign sts.byte_last   = byte_ff == 3'd7;
   assign sts.probes_done = {1'b0, probe_ff} >= {1'b0, lim_eff};
   assign sts.slot_empty  = rd_hash_ff == 64'd0;
   assign sts.slot_match  = (rd_hash_ff == fh_ff) && (rd_depth_ff == depth_ff);
   assign sts.frames_done = i_ff == depth_ff;
   assign sts.frame_eq    = rd_frame_ff == rd_pend_ff;

   always_comb begin
      hash_in     = hash_ff;
      pend_cnt_in = pend_cnt_ff;
      total_in    = total_ff;
      limit_in    = limit_ff;
      clr_in      = clr_ff;
      if (cmd.clr_step) begin
         clr_in = clr_ff + 1'b1;
      end
      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end
      if (cmd.hash_step) begin
         hash_in = fold;
         if (byte_ff == 3'd7) begin
            pend_cnt_in = pend_cnt_ff + 1'b1;
         end
      end
      if (cmd.out_load && cmd.kind != sih_pkg::KIND_READ) begin
         hash_in     = sih_pkg::FNV_BASIS;
         pend_cnt_in = '0;
      end
      if (cmd.out_load && cmd.kind == sih_pkg::KIND_INSERTED && total_ff != sih_pkg::TOTAL_MAX) begin
         total_in = total_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff     <= sih_pkg::FNV_BASIS;
         pend_cnt_ff <= '0;
         total_ff    <= '0;
         limit_ff    <= sih_pkg::LIMIT_RESET;
         clr_ff      <= '0;
      end else begin
         hash_ff     <= hash_in;
         pend_cnt_ff <= pend_cnt_in;
         total_ff    <= total_in;
         limit_ff    <= limit_in;
         clr_ff      <= clr_in;
      end
   end

   // request capture, probe walk and frame index
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         type_ff   <= req_type;
         last_ff   <= req_last_frame;
         slot_ff   <= req_slot_id;
         findex_ff <= req_frame_index;
         frame_ff  <= req_frame_addr;
         byte_ff   <= '0;
      end else if (cmd.hash_step) begin
         frame_ff <= frame_ff >> 8;
         byte_ff  <= byte_ff + 1'b1;
      end
      if (cmd.start_probe) begin
         fh_ff    <= adj_hash;
         depth_ff <= pend_cnt_ff;
         idx_ff   <= adj_hash[sih_pkg::SLOT_W-1:0];
         probe_ff <= '0;
      end else if (cmd.next_probe) begin
         idx_ff   <= idx_ff + 1'b1;
         probe_ff <= probe_ff + 1'b1;
      end
      if (cmd.ins_meta || cmd.cmp_start) begin
         i_ff <= '0;
      end else if (cmd.copy_write || cmd.cmp_next) begin
         i_ff <= i_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req && !req_type && pend_cnt_ff != sih_pkg::CNT_W'(sih_pkg::MAX_DEPTH)) begin
         pend_mem[pend_cnt_ff[sih_pkg::IDX_W-1:0]] <= req_frame_addr;
      end
      if (cmd.frame_read) begin
         rd_pend_ff <= pend_mem[i_ff[sih_pkg::IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         slot_hash_mem[clr_ff]  <= '0;
         slot_depth_mem[clr_ff] <= '0;
      end else if (cmd.ins_meta) begin
         slot_hash_mem[idx_ff]  <= fh_ff;
         slot_depth_mem[idx_ff] <= depth_ff;
      end
      if (cmd.slot_read) begin
         rd_hash_ff  <= slot_hash_mem[meta_addr];
         rd_depth_ff <= slot_depth_mem[meta_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.copy_write) begin
         slot_frames_mem[{idx_ff, i_ff[sih_pkg::IDX_W-1:0]}] <= rd_pend_ff;
      end
      if (cmd.frame_read || cmd.slot_read) begin
         rd_frame_ff <= slot_frames_mem[fr_addr];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_frame_out    <= '0;
         rsp_stored_count <= total_in;
         rsp_stack_depth  <= depth_ff;
         rsp_result_id    <= idx_ff;
         case (cmd.kind)
            sih_pkg::KIND_FOUND: begin
               rsp_status <= sih_pkg::ST_FOUND;
            end
            sih_pkg::KIND_INSERTED: begin
               rsp_status <= sih_pkg::ST_INSERTED;
            end
            sih_pkg::KIND_FULL: begin
               rsp_status    <= sih_pkg::ST_FULL;
               rsp_result_id <= '0;
            end
            sih_pkg::KIND_READ: begin
               rsp_result_id <= slot_ff;
               if (rd_hash_ff < 64'd2) begin
                  rsp_status      <= sih_pkg::ST_EMPTY;
                  rsp_stack_depth <= '0;
               end else begin
                  rsp_status      <= sih_pkg::ST_READ_OK;
                  rsp_stack_depth <= rd_depth_ff;
                  if ({1'b0, findex_ff} < rd_depth_ff) begin
                     rsp_frame_out <= rd_frame_ff;
                  end
               end
            end
            default: begin
               rsp_status <= sih_pkg::ST_FULL;
            end
         endcase
      end
   end

   pend_bounded: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff <= sih_pkg::CNT_W'(sih_pkg::MAX_DEPTH))
      else $error("pending count above max depth");
   probe_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.next_probe |-> probe_ff < lim_eff)
      else $error("probe past limit");
   copy_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.copy_write |-> i_ff < depth_ff)
      else $error("frame copy past depth");

endmodule

### hdl/sih_ctrl.sv
// controller state machine for the stack intern hash table
module sih_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  sih_pkg::sih_status_type sts,
   output sih_pkg::sih_cmd_type    cmd
);

   typedef enum logic [3:0] {
      CLEAR,
      IDLE,
      DISPATCH,
      HASH,
      PROBE_START,
      PROBE_RD,
      PROBE_CHK,
      CMP_RD,
      CMP_CHK,
      COPY_RD,
      COPY_WR,
      OUTPUT
   } state_type;

   state_type state_ff, state_in;
   sih_pkg::out_kind_type kind_ff, kind_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      cmd.kind = kind_ff;
      case (state_ff)
         CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = DISPATCH;
            end
         end
         DISPATCH: begin
            if (sts.req_is_read) begin
               cmd.slot_read = 1'b1;
               kind_in       = sih_pkg::KIND_READ;
               state_in      = OUTPUT;
            end else if (!sts.pend_full) begin
               state_in = HASH;
            end else if (sts.last_flag) begin
               state_in = PROBE_START;
            end else begin
               state_in = IDLE;
            end
         end
         HASH: begin
            cmd.hash_step = 1'b1;
            if (sts.byte_last) begin
               state_in = sts.last_flag ? PROBE_START : IDLE;
            end
         end
         PROBE_START: begin
            cmd.start_probe = 1'b1;
            state_in        = PROBE_RD;
         end
         PROBE_RD: begin
            if (sts.probes_done) begin
               kind_in  = sih_pkg::KIND_FULL;
               state_in = OUTPUT;
            end else begin
               cmd.slot_read = 1'b1;
               state_in      = PROBE_CHK;
            end
         end
         PROBE_CHK: begin
            if (sts.slot_empty) begin
               cmd.ins_meta = 1'b1;
               state_in     = COPY_RD;
            end else if (sts.slot_match) begin
               cmd.cmp_start = 1'b1;
               state_in      = CMP_RD;
            end else begin
               cmd.next_probe = 1'b1;
               state_in       = PROBE_RD;
            end
         end
         CMP_RD: begin
            if (sts.frames_done) begin
               kind_in  = sih_pkg::KIND_FOUND;
               state_in = OUTPUT;
            end else begin
               cmd.frame_read = 1'b1;
               state_in       = CMP_CHK;
            end
         end
         CMP_CHK: begin
            if (sts.frame_eq) begin
               cmd.cmp_next = 1'b1;
               state_in     = CMP_RD;
            end else begin
               cmd.next_probe = 1'b1;
               state_in       = PROBE_RD;
            end
         end
         COPY_RD: begin
            if (sts.frames_done) begin
               kind_in  = sih_pkg::KIND_INSERTED;
               state_in = OUTPUT;
            end else begin
               cmd.frame_read = 1'b1;
               state_in       = COPY_WR;
            end
         end
         COPY_WR: begin
            cmd.copy_write = 1'b1;
            state_in       = COPY_RD;
         end
         OUTPUT: begin
            if (rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         kind_ff      <= sih_pkg::KIND_FULL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");
   clear_first: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall)
      else $error("request taken before table clear");
   check_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == CMP_CHK |-> $past(state_ff) == CMP_RD)
      else $error("frame compare without a read");

endmodule

### hdl/stack_intern_hash_table.sv
// top level of the stack intern hash table
//
// interns call stacks into a 1024-slot table with 64 frames per slot
// request channel (req_): req_type 0 sends one frame of a stack, with
// req_last_frame marking the end; req_type 1 reads one frame of a slot
// result channel (rsp_): one result per read and per last frame
// an intern frame is captured, dispatched and hashed in 8 hash steps,
// one FNV-1a byte fold per cycle in the hash unit
// a last frame then probes: each slot examined, each frame compared
// against a candidate and each frame copied on insert is read and then
// checked or written, all through single-port slot and frame memories
// a read reads its slot in the dispatch state, then loads its result
// csr_wr_en writes the probe limit; it is taken in any cycle
// reset clears all 1024 slots of the slot tables, during which req_stall
// stays high; the result register holds its request while rsp_stall is
// high and the next request waits for it only when its result is ready
module stack_intern_hash_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [63:0] req_frame_addr,
   input  logic        req_last_frame,
   input  logic [9:0]  req_slot_id,
   input  logic [5:0]  req_frame_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_result_id,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_frame_out,
   output logic [6:0]  rsp_stack_depth,
   output logic [10:0] rsp_stored_count,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   sih_pkg::sih_cmd_type    cmd;
   sih_pkg::sih_status_type sts;

   sih_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sih_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_type         (req_type),
      .req_frame_addr   (req_frame_addr),
      .req_last_frame   (req_last_frame),
      .req_slot_id      (req_slot_id),
      .req_frame_index  (req_frame_index),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_result_id    (rsp_result_id),
      .rsp_status       (rsp_status),
      .rsp_frame_out    (rsp_frame_out),
      .rsp_stack_depth  (rsp_stack_depth),
      .rsp_stored_count (rsp_stored_count)
   );

endmodule
